// ===== hw/rtl/nut_pkg.sv =====
`timescale 1ns / 1ps
// Package of the node unique table: sizes, codes, the queued job word, the slot entry
// and the FNV-1a round. No dependencies.
package nut_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int VAR_BITS    = 20;
    localparam int ARC_BITS    = 32;
    localparam int REF_BITS    = 16;
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    typedef enum logic [1:0] {
        FUNC_LOOKUP  = 2'd0,
        FUNC_CREATE  = 2'd1,
        FUNC_ADD_REF = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MIX_VAR, F_MIX_LOW, F_MIX_HIGH, F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR, B_IDLE, B_READ, B_CMP
    } back_state_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [VAR_BITS-1:0] var_number;
        logic [ARC_BITS-1:0] low_arc;
        logic [ARC_BITS-1:0] high_arc;
        logic                reduced_mark;
        logic [IDX_BITS-1:0] node_index;
        logic [IDX_BITS-1:0] hash;
    } job_t;

    typedef struct packed {
        logic                used;
        logic [VAR_BITS-1:0] var_number;
        logic [ARC_BITS-1:0] low_arc;
        logic [ARC_BITS-1:0] high_arc;
        logic                reduced;
        logic [REF_BITS-1:0] refs;
    } entry_t;

    // The prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
    function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [63:0] x);
        logic [63:0] m;
        m = h ^ x;
        return m + (m << 1) + (m << 4) + (m << 5) + (m << 7) + (m << 8) + (m << 40);
    endfunction

endpackage

// ===== hw/rtl/nut_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the node unique table.
// Depends on nut_pkg.
interface nut_req_if import nut_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [VAR_BITS-1:0] var_number;
    logic [ARC_BITS-1:0] low_arc;
    logic [ARC_BITS-1:0] high_arc;
    logic                reduced_mark;
    logic [IDX_BITS-1:0] node_index;

    modport source (output valid, func, var_number, low_arc, high_arc, reduced_mark,
                    node_index, input ready);
    modport sink (input valid, func, var_number, low_arc, high_arc, reduced_mark,
                  node_index, output ready);
endinterface

interface nut_rsp_if import nut_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_BITS-1:0] slot_index;
    logic [2:0]          status;
    logic [REF_BITS-1:0] count_after;
    logic [CNT_BITS-1:0] stored_nodes;
    logic [CNT_BITS-1:0] alive_nodes;

    modport source (output valid, slot_index, status, count_after, stored_nodes,
                    alive_nodes, input ready);
    modport sink (input valid, slot_index, status, count_after, stored_nodes,
                  alive_nodes, output ready);
endinterface

// ===== hw/rtl/nut_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts a request word and hashes its key with FNV-1a, one round a cycle.
// Depends on nut_pkg and nut_if.
module nut_front import nut_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear_done,
    nut_req_if.sink       req,
    output logic          push_valid,
    input  logic          push_ready,
    output job_t          push_data
);

    front_state_t state_reg, state_next;
    job_t         job_reg;
    logic [63:0]  hash_reg, hash_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:     if (req.valid && clear_done) state_next = F_MIX_VAR;
            F_MIX_VAR:  state_next = F_MIX_LOW;
            F_MIX_LOW:  state_next = F_MIX_HIGH;
            F_MIX_HIGH: state_next = F_PUSH;
            F_PUSH:     if (push_ready) state_next = F_IDLE;
            default:    state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready  = (state_reg == F_IDLE) && clear_done;
        push_valid = (state_reg == F_PUSH);
        push_data  = job_reg;
        push_data.hash = hash_reg[IDX_BITS-1:0];
        hash_next  = hash_reg;
        case (state_reg)
            F_IDLE:     hash_next = FNV_BASIS;
            F_MIX_VAR:  hash_next = fnv_round(hash_reg, 64'(job_reg.var_number));
            F_MIX_LOW:  hash_next = fnv_round(hash_reg, 64'(job_reg.low_arc));
            F_MIX_HIGH: hash_next = fnv_round(hash_reg, 64'(job_reg.high_arc));
            default:    hash_next = hash_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        if (req.valid && req.ready)
        begin
            job_reg.func         <= req.func;
            job_reg.var_number   <= req.var_number;
            job_reg.low_arc      <= req.low_arc;
            job_reg.high_arc     <= req.high_arc;
            job_reg.reduced_mark <= req.reduced_mark;
            job_reg.node_index   <= req.node_index;
            job_reg.hash         <= '0;
        end
    end

endmodule

// ===== hw/rtl/nut_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue of hashed jobs between the front and back ends.
// Depends on nut_pkg.
module nut_queue import nut_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    job_t                store_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]   fill_reg, fill_next;
    logic                do_push, do_pop;

    assign push_ready = (fill_reg != PTR_BITS'(0) + (PTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/nut_back.sv =====
`timescale 1ns / 1ps
// Back end: clears the slot memory after reset, probes it quadratically, updates slots
// and counters and holds the response word. Depends on nut_pkg and nut_if.
module nut_back import nut_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    output logic    clear_done,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  job_t    pop_data,
    nut_rsp_if.source rsp
);

    entry_t mem [TABLE_DEPTH];

    back_state_t         state_reg, state_next;
    job_t                job_reg;
    entry_t              rd_reg;
    logic [IDX_BITS-1:0] addr_reg, addr_next;
    logic [IDX_BITS-1:0] off_reg, off_next;
    logic [IDX_BITS-1:0] probe_reg, probe_next;
    logic [IDX_BITS-1:0] clr_reg;
    logic [CNT_BITS-1:0] used_reg, used_next, alive_reg, alive_next;

    logic                out_valid_reg;
    logic [IDX_BITS-1:0] out_slot_reg;
    status_t             out_status_reg;
    logic [REF_BITS-1:0] out_count_reg;

    logic                out_free, is_key, is_create, match, finish, last_probe;
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    entry_t              wdata, bumped;
    logic [IDX_BITS-1:0] res_slot;
    status_t             res_status;
    logic [REF_BITS-1:0] res_count;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign is_key     = (job_reg.func == FUNC_LOOKUP) || (job_reg.func == FUNC_CREATE);
    assign is_create  = (job_reg.func == FUNC_CREATE);
    assign match      = rd_reg.used && (rd_reg.var_number == job_reg.var_number)
                        && (rd_reg.low_arc == job_reg.low_arc)
                        && (rd_reg.high_arc == job_reg.high_arc);
    assign last_probe = (probe_reg == IDX_BITS'(TABLE_DEPTH - 1));
    assign finish     = !is_key || !rd_reg.used || match || last_probe;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (clr_reg == IDX_BITS'(TABLE_DEPTH - 1)) state_next = B_IDLE;
            B_IDLE:  if (pop_valid) state_next = B_READ;
            B_READ:  state_next = B_CMP;
            B_CMP:
            begin
                if (!finish)
                    state_next = B_READ;
                else if (out_free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        clear_done = (state_reg != B_CLEAR);
        pop_ready  = (state_reg == B_IDLE);
        addr_next  = addr_reg;
        off_next   = off_reg;
        probe_next = probe_reg;
        used_next  = used_reg;
        alive_next = alive_reg;
        we         = 1'b0;
        waddr      = addr_reg;
        wdata      = rd_reg;
        res_slot   = '0;
        res_status = ST_NOT_FOUND;
        res_count  = '0;

        bumped = rd_reg;
        if (rd_reg.refs != REF_MAX) bumped.refs = rd_reg.refs + 1'b1;

        case (state_reg)
            B_CLEAR:
            begin
                we         = 1'b1;
                waddr      = clr_reg;
                wdata.used = 1'b0;
            end
            B_IDLE:
            begin
                off_next   = '0;
                probe_next = '0;
                if (pop_data.func == FUNC_LOOKUP || pop_data.func == FUNC_CREATE)
                    addr_next = pop_data.hash;
                else
                    addr_next = pop_data.node_index;
            end
            B_CMP:
            begin
                if (is_key)
                begin
                    if (!rd_reg.used)
                    begin
                        if (is_create)
                        begin
                            wdata.used       = 1'b1;
                            wdata.var_number = job_reg.var_number;
                            wdata.low_arc    = job_reg.low_arc;
                            wdata.high_arc   = job_reg.high_arc;
                            wdata.reduced    = job_reg.reduced_mark;
                            wdata.refs       = REF_BITS'(1);
                            we               = out_free;
                            res_slot         = addr_reg;
                            res_status       = ST_INSERTED;
                            res_count        = REF_BITS'(1);
                            used_next        = used_reg + 1'b1;
                            alive_next       = alive_reg + 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        res_slot   = addr_reg;
                        res_status = ST_FOUND;
                        res_count  = rd_reg.refs;
                        if (is_create)
                        begin
                            wdata     = bumped;
                            we        = out_free;
                            res_count = bumped.refs;
                            if (rd_reg.refs == '0) alive_next = alive_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_status = is_create ? ST_FULL : ST_NOT_FOUND;
                        probe_next = probe_reg + 1'b1;
                        off_next   = off_reg + {probe_reg[IDX_BITS-2:0], 1'b1};
                        addr_next  = job_reg.hash + off_next;
                    end
                end
                else if (!rd_reg.used)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_slot   = addr_reg;
                    res_status = ST_FOUND;
                    we         = out_free;
                    if (job_reg.func == FUNC_ADD_REF)
                    begin
                        wdata = bumped;
                        if (rd_reg.refs == '0) alive_next = alive_reg + 1'b1;
                    end
                    else if (rd_reg.refs != '0)
                    begin
                        wdata.refs = rd_reg.refs - 1'b1;
                        if (rd_reg.refs == REF_BITS'(1)) alive_next = alive_reg - 1'b1;
                    end
                    res_count = wdata.refs;
                end
                if (finish && !out_free)
                begin
                    used_next  = used_reg;
                    alive_next = alive_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            alive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            alive_reg <= alive_next;
            if (state_reg == B_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == B_CMP && finish && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        off_reg   <= off_next;
        probe_reg <= probe_next;
        if (state_reg == B_IDLE && pop_valid) job_reg <= pop_data;
        if (state_reg == B_READ) rd_reg <= mem[addr_reg];
        if (we) mem[waddr] <= wdata;
        if (state_reg == B_CMP && finish && out_free)
        begin
            out_slot_reg   <= res_slot;
            out_status_reg <= res_status;
            out_count_reg  <= res_count;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.slot_index   = out_slot_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.count_after  = out_count_reg;
    assign rsp.stored_nodes = used_reg;
    assign rsp.alive_nodes  = alive_reg;

    a_alive_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        alive_reg <= used_reg)
        else $error("alive total exceeds stored total");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("stored total exceeds table depth");
    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !out_valid_reg)
        else $error("response during clearing pass");
    a_counts_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> $stable(used_reg) && $stable(alive_reg))
        else $error("counters moved under a stalled response");

endmodule

// ===== hw/rtl/node_unique_table.sv =====
`timescale 1ns / 1ps
// Node unique table top: hashing front end, job queue, probing back end.
// After reset a clearing pass over every slot runs before the first request word is taken.
// A request word passes the hash rounds over var_number, low_arc and high_arc, then the queue;
// the back end then reads and compares one slot per probe, and a reference adjustment needs one probe.
// The front end takes a new word only once it has pushed the last one, while the queue lets it
// hash ahead as the back end probes; long probe chains slow the flow. Depends on nut_pkg and nut_if.
module node_unique_table import nut_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    nut_req_if.sink   req,
    nut_rsp_if.source rsp
);

    logic clear_done;
    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_data, pop_data;

    nut_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    nut_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    nut_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .rsp        (rsp)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench of node_unique_table: directed key and reference-count words, then random traffic,
// each response checked against a behavioral table model. Also depends on nut_pkg, nut_if.
module tb;
    import nut_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [IDX_BITS-1:0] slot_index;
        logic [2:0]          status;
        logic [REF_BITS-1:0] count_after;
        logic [CNT_BITS-1:0] stored_nodes;
        logic [CNT_BITS-1:0] alive_nodes;
    } answer_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [VAR_BITS-1:0] var_number;
        logic [ARC_BITS-1:0] low_arc;
        logic [ARC_BITS-1:0] high_arc;
        logic                reduced_mark;
        logic [IDX_BITS-1:0] node_index;
    } word_t;

    typedef struct {
        word_t   w;
        logic    typed;
        answer_t ans;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nut_req_if req ();
    nut_rsp_if rsp ();

    node_unique_table dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #1 clk = ~clk;

    logic                used_tbl [TABLE_DEPTH];
    logic [VAR_BITS-1:0] var_tbl  [TABLE_DEPTH];
    logic [ARC_BITS-1:0] low_tbl  [TABLE_DEPTH];
    logic [ARC_BITS-1:0] high_tbl [TABLE_DEPTH];
    logic [REF_BITS-1:0] refs_tbl [TABLE_DEPTH];
    logic [CNT_BITS-1:0] used_count;
    logic [CNT_BITS-1:0] alive_count;

    answer_t pending_answers[$];
    word_t   key_pool[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      hold_off = 1'b0;
    bit      stim_done = 1'b0;

    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] x);
        logic [63:0] m;
        m = h ^ x;
        return m * FNV_PRIME;
    endfunction

    function automatic void bump_refs(input int s);
        if (refs_tbl[s] == 0)
            alive_count++;
        if (refs_tbl[s] != REF_MAX)
            refs_tbl[s]++;
    endfunction

    function automatic answer_t apply_word(input word_t w);
        answer_t a;
        logic [63:0] h;
        int s;
        bit done;
        a = '0;
        if (w.func == FUNC_LOOKUP || w.func == FUNC_CREATE) begin
            h = fnv_mix(fnv_mix(fnv_mix(FNV_BASIS, 64'(w.var_number)), 64'(w.low_arc)),
                        64'(w.high_arc));
            a.status = (w.func == FUNC_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
            done = 1'b0;
            for (longint i = 0; i < TABLE_DEPTH && !done; i++) begin
                s = int'((h + 64'(i * i)) % TABLE_DEPTH);
                if (!used_tbl[s]) begin
                    if (w.func == FUNC_CREATE) begin
                        used_tbl[s] = 1'b1;
                        var_tbl[s] = w.var_number;
                        low_tbl[s] = w.low_arc;
                        high_tbl[s] = w.high_arc;
                        refs_tbl[s] = REF_BITS'(1);
                        used_count++;
                        alive_count++;
                        a.slot_index = IDX_BITS'(s);
                        a.status = ST_INSERTED;
                        a.count_after = REF_BITS'(1);
                    end
                    done = 1'b1;
                end
                else if (var_tbl[s] == w.var_number && low_tbl[s] == w.low_arc
                         && high_tbl[s] == w.high_arc) begin
                    if (w.func == FUNC_CREATE)
                        bump_refs(s);
                    a.slot_index = IDX_BITS'(s);
                    a.status = ST_FOUND;
                    a.count_after = refs_tbl[s];
                    done = 1'b1;
                end
            end
        end
        else if (used_tbl[w.node_index]) begin
            s = int'(w.node_index);
            if (w.func == FUNC_ADD_REF)
                bump_refs(s);
            else if (refs_tbl[s] != 0) begin
                refs_tbl[s]--;
                if (refs_tbl[s] == 0)
                    alive_count--;
            end
            a.slot_index = IDX_BITS'(s);
            a.status = ST_FOUND;
            a.count_after = refs_tbl[s];
        end
        else
            a.status = ST_EMPTY;
        a.stored_nodes = used_count;
        a.alive_nodes = alive_count;
        return a;
    endfunction

    function automatic word_t make_word(input logic [1:0] f, input logic [VAR_BITS-1:0] v,
                                        input logic [ARC_BITS-1:0] lo,
                                        input logic [ARC_BITS-1:0] hi,
                                        input logic r, input logic [IDX_BITS-1:0] ni);
        word_t w;
        w.func = f;
        w.var_number = v;
        w.low_arc = lo;
        w.high_arc = hi;
        w.reduced_mark = r;
        w.node_index = ni;
        return w;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int pick;
        w = make_word(2'($urandom_range(0, 3)), VAR_BITS'($urandom), $urandom, $urandom,
                      1'($urandom), IDX_BITS'($urandom));
        pick = $urandom_range(0, 99);
        if (key_pool.size() > 0 && pick < 60) begin
            word_t k;
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            w.var_number = k.var_number;
            w.low_arc = k.low_arc;
            w.high_arc = k.high_arc;
        end
        else if (pick < 70) begin
            w.var_number = VAR_BITS'($urandom_range(0, 3));
            w.low_arc = ARC_BITS'($urandom_range(0, 3));
            w.high_arc = ARC_BITS'($urandom_range(0, 3));
        end
        if (w.func >= FUNC_ADD_REF && $urandom_range(0, 3) != 0) begin
            int s;
            s = $urandom_range(0, TABLE_DEPTH - 1);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (used_tbl[(s + i) % TABLE_DEPTH]) begin
                    w.node_index = IDX_BITS'((s + i) % TABLE_DEPTH);
                    break;
                end
        end
        return w;
    endfunction

    function automatic int key_slot_of(input word_t w);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (used_tbl[i] && var_tbl[i] == w.var_number && low_tbl[i] == w.low_arc
                && high_tbl[i] == w.high_arc)
                return i;
        return 0;
    endfunction

    task automatic send_word(input word_t w);
        req.valid <= 1'b1;
        req.func <= w.func;
        req.var_number <= w.var_number;
        req.low_arc <= w.low_arc;
        req.high_arc <= w.high_arc;
        req.reduced_mark <= w.reduced_mark;
        req.node_index <= w.node_index;
        do
            @(posedge clk);
        while (!req.ready);
        pending_answers.push_back(apply_word(w));
        if (w.func == FUNC_CREATE)
            key_pool.push_back(w);
    endtask

    task automatic gap();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    initial
    begin
        row_t rows[$];
        row_t r;
        word_t w;
        int burst;
        int n;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            used_tbl[i] = 1'b0;
            refs_tbl[i] = '0;
        end
        used_count = '0;
        alive_count = '0;
        req.valid = 1'b0;
        req.func = FUNC_LOOKUP;
        req.var_number = '0;
        req.low_arc = '0;
        req.high_arc = '0;
        req.reduced_mark = 1'b0;
        req.node_index = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        r.typed = 1'b1;
        r.w = make_word(FUNC_LOOKUP, '0, '0, '0, 1'b0, '0);
        r.ans = '{0, ST_NOT_FOUND, 0, 0, 0};
        rows.push_back(r);
        r.w = make_word(FUNC_ADD_REF, '1, '1, '1, 1'b1, '1);
        r.ans = '{0, ST_EMPTY, 0, 0, 0};
        rows.push_back(r);
        r.w = make_word(FUNC_RELEASE, '0, '0, '0, 1'b0, '0);
        rows.push_back(r);
        r.typed = 1'b0;
        r.w = make_word(FUNC_CREATE, '0, '0, '0, 1'b0, '0);
        rows.push_back(r);
        r.w = make_word(FUNC_CREATE, '1, '1, '1, 1'b1, '1);
        rows.push_back(r);
        rows.push_back(r);
        r.w = make_word(FUNC_LOOKUP, '1, '1, '1, 1'b0, '0);
        rows.push_back(r);
        r.w = make_word(FUNC_CREATE, 20'h5A5A5, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0, '0);
        rows.push_back(r);
        r.w = make_word(FUNC_CREATE, 20'hA5A5A, 32'h5A5A5A5A, 32'hA5A5A5A5, 1'b1, '0);
        rows.push_back(r);
        for (int i = 0; i < 4; i++)
        begin
            r.w = make_word(FUNC_CREATE, VAR_BITS'(i), 32'd7, 32'd9, 1'(i), '0);
            rows.push_back(r);
        end
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                send_word(rows[i].w);
                if (pending_answers[$] != rows[i].ans)
                begin
                    $error("row %0d answer expected %h predicted %h", i, rows[i].ans,
                           pending_answers[$]);
                    errors++;
                end
                pending_answers[$] = rows[i].ans;
            end
            else
                send_word(rows[i].w);
            if ($urandom_range(0, 1))
                gap();
        end
        req.valid <= 1'b0;
        wait (pending_answers.size() == 0);

        // Release until the count is zero, then release again; raise another count a few times.
        for (int j = 0; j < 4; j++)
            send_word(make_word(FUNC_RELEASE, '0, '0, '0, 1'b0,
                                IDX_BITS'(key_slot_of(rows[3].w))));
        n = key_slot_of(rows[4].w);
        for (int j = 0; j < 8; j++)
            send_word(make_word(FUNC_ADD_REF, '0, '0, '0, 1'b0, IDX_BITS'(n)));
        send_word(make_word(FUNC_CREATE, '1, '1, '1, 1'b0, '0));
        send_word(make_word(FUNC_RELEASE, '0, '0, '0, 1'b0, IDX_BITS'(n)));

        n = 0;
        hold_off = 1'b1;
        while (n < 450)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 450; b++, n++)
                send_word(random_word());
            if (n > 40)
                hold_off = 1'b0;
            if ($urandom_range(0, 3) != 0)
                gap();
        end
        // Create a run of keys back to back, some already stored, then look up a key that is absent.
        for (int j = 0; j < 30; j++)
            send_word(make_word(FUNC_CREATE, VAR_BITS'(j), 32'(j * 3), '0, 1'b0, '0));
        send_word(make_word(FUNC_LOOKUP, '1, '0, '1, 1'b0, '0));
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        int hold;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                for (hold = 0; hold < 200; hold++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            case ($urandom_range(0, 7))
                0, 1: rsp.ready <= 1'b0;
                default: rsp.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response word with no request pending");
                errors++;
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (rsp.slot_index !== exp_ans.slot_index)
                begin
                    $error("slot_index expected %0d got %0d", exp_ans.slot_index,
                           rsp.slot_index);
                    errors++;
                end
                if (rsp.status !== exp_ans.status)
                begin
                    $error("status expected %0d got %0d", exp_ans.status, rsp.status);
                    errors++;
                end
                if (rsp.count_after !== exp_ans.count_after)
                begin
                    $error("count_after expected %0d got %0d", exp_ans.count_after,
                           rsp.count_after);
                    errors++;
                end
                if (rsp.stored_nodes !== exp_ans.stored_nodes)
                begin
                    $error("stored_nodes expected %0d got %0d", exp_ans.stored_nodes,
                           rsp.stored_nodes);
                    errors++;
                end
                if (rsp.alive_nodes !== exp_ans.alive_nodes)
                begin
                    $error("alive_nodes expected %0d got %0d", exp_ans.alive_nodes,
                           rsp.alive_nodes);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done && pending_answers.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/nut_pkg.sv
hw/rtl/nut_if.sv
hw/rtl/nut_front.sv
hw/rtl/nut_queue.sv
hw/rtl/nut_back.sv
hw/rtl/node_unique_table.sv
tb/tb.sv
